// File: src/lkvc_pkg.sv
// shared types and constants for the lru key-value cache
// no dependencies; imported by every module of the block
package lkvc_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SEARCH
  } state_e;

  typedef enum logic [1:0] {
    UPD_NONE,
    UPD_PROMOTE,
    UPD_INSERT
  } upd_op_e;

  typedef struct packed {
    upd_op_e          op;
    logic             wr_value;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } upd_t;

  typedef struct packed {
    logic active;
    logic found;
    logic free_found;
    logic old_found;
  } tok_flags_t;

endpackage

// File: src/lkvc_cell.sv
// one cache entry: key, value, valid and recency rank
// adds its own match, free and oldest findings to the search token passing by
// depends on lkvc_pkg
module lkvc_cell #(
  parameter int IDXW = 4,
  parameter int ME   = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [lkvc_pkg::KEY_W-1:0] search_key,
  input  lkvc_pkg::tok_flags_t      in_flags,
  input  logic [IDXW-1:0]           in_found_idx,
  input  logic [IDXW-1:0]           in_found_rank,
  input  logic [lkvc_pkg::VAL_W-1:0] in_found_value,
  input  logic [IDXW-1:0]           in_free_idx,
  input  logic [IDXW-1:0]           in_old_idx,
  input  logic [IDXW-1:0]           in_old_rank,
  output lkvc_pkg::tok_flags_t      out_flags,
  output logic [IDXW-1:0]           out_found_idx,
  output logic [IDXW-1:0]           out_found_rank,
  output logic [lkvc_pkg::VAL_W-1:0] out_found_value,
  output logic [IDXW-1:0]           out_free_idx,
  output logic [IDXW-1:0]           out_old_idx,
  output logic [IDXW-1:0]           out_old_rank,
  input  lkvc_pkg::upd_t            upd,
  input  logic [IDXW-1:0]           upd_slot,
  input  logic [IDXW-1:0]           upd_rank
);
  import lkvc_pkg::*;

  logic [KEY_W-1:0] entry_key;
  logic [VAL_W-1:0] entry_value;
  logic             valid;
  logic [IDXW-1:0]  rank;

  logic             hit_here;
  logic             is_me;
  tok_flags_t       flags_next;
  logic [IDXW-1:0]  found_idx_next;
  logic [IDXW-1:0]  found_rank_next;
  logic [VAL_W-1:0] found_value_next;
  logic [IDXW-1:0]  free_idx_next;
  logic [IDXW-1:0]  old_idx_next;
  logic [IDXW-1:0]  old_rank_next;

  assign hit_here = valid && (entry_key == search_key);
  assign is_me    = (upd_slot == IDXW'(ME));

  always_comb begin
    flags_next       = in_flags;
    found_idx_next   = in_found_idx;
    found_rank_next  = in_found_rank;
    found_value_next = in_found_value;
    free_idx_next    = in_free_idx;
    old_idx_next     = in_old_idx;
    old_rank_next    = in_old_rank;
    if (hit_here && !in_flags.found) begin
      flags_next.found = 1'b1;
      found_idx_next   = IDXW'(ME);
      found_rank_next  = rank;
      found_value_next = entry_value;
    end
    if (!valid && !in_flags.free_found) begin
      flags_next.free_found = 1'b1;
      free_idx_next         = IDXW'(ME);
    end
    if (valid && (!in_flags.old_found || rank > in_old_rank)) begin
      flags_next.old_found = 1'b1;
      old_idx_next         = IDXW'(ME);
      old_rank_next        = rank;
    end
  end

  // token stage toward the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      out_flags <= '0;
    end else begin
      out_flags <= flags_next;
    end
  end

  always_ff @(posedge clk) begin
    out_found_idx   <= found_idx_next;
    out_found_rank  <= found_rank_next;
    out_found_value <= found_value_next;
    out_free_idx    <= free_idx_next;
    out_old_idx     <= old_idx_next;
    out_old_rank    <= old_rank_next;
  end

  // recency and valid
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else begin
      case (upd.op)
        UPD_PROMOTE: begin
          if (is_me) begin
            rank <= '0;
          end else if (valid && rank < upd_rank) begin
            rank <= IDXW'(rank + 1'b1);
          end
        end
        UPD_INSERT: begin
          if (is_me) begin
            valid <= 1'b1;
            rank  <= '0;
          end else if (valid) begin
            rank <= IDXW'(rank + 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (is_me && upd.op == UPD_INSERT) begin
      entry_key   <= upd.key;
      entry_value <= upd.value;
    end else if (is_me && upd.op == UPD_PROMOTE && upd.wr_value) begin
      entry_value <= upd.value;
    end
  end

endmodule

// File: src/lru_key_value_cache.sv
// top level of the lru key-value cache: control, capacity register, cell chain
// depends on lkvc_pkg and lkvc_cell
//
//   channel   handshake            payload
//   request   start / busy         action, key, value
//   result    done (strobe)        hit, read_value
//   config    capacity_wr          capacity
//
// each request passes a search token down the cell chain one cell per cycle,
// then the update is applied to all cells at once. a get's result is strobed
// on done once the token has left the last cell; busy falls in that same cycle,
// so the next request can be taken at its end.
// a put gives no result. reset clears all entries and sets capacity to 16.
// results cannot be stalled; done is high for exactly one cycle per get.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action,
  input  logic [lkvc_pkg::KEY_W-1:0] key,
  input  logic [lkvc_pkg::VAL_W-1:0] value,
  output logic                       done,
  output logic                       hit,
  output logic [lkvc_pkg::VAL_W-1:0] read_value,
  input  logic                       capacity_wr,
  input  logic [lkvc_pkg::CAP_W-1:0] capacity
);
  import lkvc_pkg::*;

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCCW = $clog2(ENTRIES + 1);
  localparam int CW   = (OCCW > CAP_W) ? OCCW : CAP_W;

  state_e           state;
  state_e           state_next;
  logic             act_q;
  logic [KEY_W-1:0] key_q;
  logic [VAL_W-1:0] val_q;
  logic [CAP_W-1:0] cap_setting;
  logic [OCCW-1:0]  occupancy;
  logic [OCCW-1:0]  occupancy_next;

  tok_flags_t       head_flags;
  tok_flags_t       chain_flags       [ENTRIES+1];
  logic [IDXW-1:0]  chain_found_idx   [ENTRIES+1];
  logic [IDXW-1:0]  chain_found_rank  [ENTRIES+1];
  logic [VAL_W-1:0] chain_found_value [ENTRIES+1];
  logic [IDXW-1:0]  chain_free_idx    [ENTRIES+1];
  logic [IDXW-1:0]  chain_old_idx     [ENTRIES+1];
  logic [IDXW-1:0]  chain_old_rank    [ENTRIES+1];

  upd_t             upd;
  logic [IDXW-1:0]  upd_slot;
  logic [IDXW-1:0]  upd_rank;
  logic             res_load;
  logic             res_hit;
  logic [VAL_W-1:0] res_value;

  logic [CW-1:0]    cap_ext;
  logic [CW-1:0]    eff_cap;
  logic [CW-1:0]    occ_ext;
  logic             full;
  logic             tail_active;

  // head of the chain
  always_comb begin
    head_flags        = '0;
    head_flags.active = (state == ST_LAUNCH);
  end
  assign chain_flags[0]       = head_flags;
  assign chain_found_idx[0]   = '0;
  assign chain_found_rank[0]  = '0;
  assign chain_found_value[0] = '0;
  assign chain_free_idx[0]    = '0;
  assign chain_old_idx[0]     = '0;
  assign chain_old_rank[0]    = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkvc_cell #(
      .IDXW (IDXW),
      .ME   (i)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .search_key      (key_q),
      .in_flags        (chain_flags[i]),
      .in_found_idx    (chain_found_idx[i]),
      .in_found_rank   (chain_found_rank[i]),
      .in_found_value  (chain_found_value[i]),
      .in_free_idx     (chain_free_idx[i]),
      .in_old_idx      (chain_old_idx[i]),
      .in_old_rank     (chain_old_rank[i]),
      .out_flags       (chain_flags[i+1]),
      .out_found_idx   (chain_found_idx[i+1]),
      .out_found_rank  (chain_found_rank[i+1]),
      .out_found_value (chain_found_value[i+1]),
      .out_free_idx    (chain_free_idx[i+1]),
      .out_old_idx     (chain_old_idx[i+1]),
      .out_old_rank    (chain_old_rank[i+1]),
      .upd             (upd),
      .upd_slot        (upd_slot),
      .upd_rank        (upd_rank)
    );
  end

  assign tail_active = chain_flags[ENTRIES].active;

  assign cap_ext = CW'(cap_setting);
  assign eff_cap = (cap_ext == '0) ? CW'(1) :
                   ((cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext);
  assign occ_ext = CW'(occupancy);
  assign full    = (occ_ext >= eff_cap) || (occ_ext >= CW'(ENTRIES));

  // decision once the token leaves the last cell
  always_comb begin
    upd            = '0;
    upd.op         = UPD_NONE;
    upd_slot       = '0;
    upd_rank       = '0;
    occupancy_next = occupancy;
    res_load       = 1'b0;
    res_hit        = 1'b0;
    res_value      = MISS_VALUE;
    if (state == ST_SEARCH && tail_active) begin
      if (act_q == ACT_GET) begin
        res_load = 1'b1;
        if (chain_flags[ENTRIES].found) begin
          res_hit   = 1'b1;
          res_value = chain_found_value[ENTRIES];
          upd.op    = UPD_PROMOTE;
          upd_slot  = chain_found_idx[ENTRIES];
          upd_rank  = chain_found_rank[ENTRIES];
        end
      end else if (chain_flags[ENTRIES].found) begin
        upd.op       = UPD_PROMOTE;
        upd.wr_value = 1'b1;
        upd.value    = val_q;
        upd_slot     = chain_found_idx[ENTRIES];
        upd_rank     = chain_found_rank[ENTRIES];
      end else begin
        upd.op    = UPD_INSERT;
        upd.key   = key_q;
        upd.value = val_q;
        if (full) begin
          upd_slot = chain_old_idx[ENTRIES];
        end else begin
          upd_slot       = chain_free_idx[ENTRIES];
          occupancy_next = OCCW'(occupancy + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (tail_active) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      act_q <= action;
      key_q <= key;
      val_q <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_setting <= CAP_RESET;
      occupancy   <= '0;
      done        <= 1'b0;
    end else begin
      if (capacity_wr) begin
        cap_setting <= capacity;
      end
      occupancy <= occupancy_next;
      done      <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      hit        <= res_hit;
      read_value <= res_value;
    end
  end

endmodule

// File: src/lkvc_checker.sv
// port-level checks for the lru key-value cache, bound to the top level
// depends on lkvc_pkg and lru_key_value_cache
module lkvc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       hit,
  input logic [lkvc_pkg::VAL_W-1:0] read_value
);
  import lkvc_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> read_value == MISS_VALUE)
    else $error("miss did not return all ones");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !busy && !done)
    else $error("busy or done after reset");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .hit        (hit),
  .read_value (read_value)
);
